@@ hw/rtl/alarm_band_classifier_core_assert.svh @@
// ----------------------------------------------------------------------------
// alarm band classifier assertion macros
// shared property wrappers for the concurrent checks at the end of the core
// ----------------------------------------------------------------------------
`ifndef ALARM_BAND_CLASSIFIER_CORE_ASSERT_SVH
`define ALARM_BAND_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ABCLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define ABCLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/abcls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abcls_pkg
// types and constants shared by the alarm band classifier modules
// ----------------------------------------------------------------------------
package abcls_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_RANGE_MIN  = 2'd0;
   localparam logic [1:0] CSR_RANGE_MAX  = 2'd1;
   localparam logic [1:0] CSR_BAND_COUNT = 2'd2;
   localparam logic [1:0] CSR_HOLDOFF_MS = 2'd3;

   localparam logic [19:0] HOLDOFF_RESET = 20'd3000;

   // severity levels
   localparam logic [1:0] SEV_WARN = 2'd2;
   localparam logic [1:0] SEV_CRIT = 2'd3;

   // alert codes
   localparam logic [1:0] ALERT_NONE = 2'd0;
   localparam logic [1:0] ALERT_WARN = 2'd1;
   localparam logic [1:0] ALERT_CRIT = 2'd2;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_BAND   = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [2:0]         slot;
      logic signed [31:0] edge_a;
      logic signed [31:0] edge_b;
      logic [1:0]         severity;
      logic signed [31:0] sample_value;
      logic [47:0]        time_ms;
   } abcls_req_type;

   typedef struct packed {
      logic               in_band;
      logic [2:0]         band_index;
      logic               band_changed;
      logic [1:0]         alert;
      logic signed [31:0] value_clamped;
   } abcls_rsp_type;

   typedef struct packed {
      logic signed [31:0] lower;
      logic signed [31:0] upper;
      logic [1:0]         level;
   } abcls_band_entry_type;

   // top level to engine
   typedef struct packed {
      logic start;
      logic take;
   } abcls_eng_ctl_type;

   // engine to top level
   typedef struct packed {
      logic idle;
      logic done;
   } abcls_eng_sts_type;

endpackage
`default_nettype wire

@@ hw/rtl/abcls_band_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abcls_band_mem
// band table memory, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module abcls_band_mem #(
   parameter int unsigned BAND_SLOTS = 8,
   parameter int unsigned IDX_W      = 3
) (
   input  wire                            clock,
   input  wire                            wr_en,
   input  wire [IDX_W-1:0]                wr_addr,
   input  abcls_pkg::abcls_band_entry_type wr_data,
   input  wire [IDX_W-1:0]                rd_addr,
   output abcls_pkg::abcls_band_entry_type rd_data
);

   abcls_pkg::abcls_band_entry_type mem_ff [BAND_SLOTS];
   abcls_pkg::abcls_band_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/abcls_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abcls_engine
// sequencer: clamps the sample, walks the band table, tracks arming and holdoff
// ----------------------------------------------------------------------------
module abcls_engine #(
   parameter int unsigned BAND_SLOTS = 8,
   parameter int unsigned IDX_W      = 3
) (
   input  wire                             clock,
   input  wire                             reset,
   input  abcls_pkg::abcls_eng_ctl_type    ctl,
   input  abcls_pkg::abcls_req_type        item,
   input  wire signed [31:0]               range_min,
   input  wire signed [31:0]               range_max,
   input  wire [3:0]                       band_count,
   input  wire [19:0]                      holdoff_ms,
   output abcls_pkg::abcls_eng_sts_type    sts,
   output abcls_pkg::abcls_rsp_type        result,
   output logic                            mem_we,
   output logic [IDX_W-1:0]                mem_waddr,
   output abcls_pkg::abcls_band_entry_type mem_wdata,
   output logic [IDX_W-1:0]                mem_raddr,
   input  abcls_pkg::abcls_band_entry_type mem_rdata
);

   localparam int unsigned CNT_W = $clog2(BAND_SLOTS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HINT  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic               wr_ff, wr_in;
   logic signed [31:0] v_ff, v_in;
   logic [47:0]        now_ff, now_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [1:0]         lvl_ff, lvl_in;
   logic [1:0]         blk_ff, blk_in;
   logic [IDX_W-1:0]   hint_ff, hint_in;
   logic               hint_valid_ff, hint_valid_in;
   logic [IDX_W-1:0]   rec_ff, rec_in;
   logic               rec_valid_ff, rec_valid_in;
   logic               armed_ff, armed_in;
   logic [47:0]        last_ff [2];
   logic [47:0]        last_in [2];
   logic [1:0]         tvalid_ff, tvalid_in;

   logic [CNT_W-1:0]   count;
   logic signed [31:0] clamp_v;
   logic signed [31:0] edge_lo;
   logic signed [31:0] edge_hi;
   logic               holds;
   logic               hint_hit;
   logic [48:0]        diff0;
   logic [48:0]        diff1;
   logic               changed;
   logic               blocked;
   logic [1:0]         alert_code;

   // effective table size
   assign count = (32'(band_count) > BAND_SLOTS) ? CNT_W'(BAND_SLOTS) : CNT_W'(band_count);

   always_comb begin
      clamp_v = item.sample_value;
      if (range_max > range_min) begin
         if (clamp_v < range_min) begin
            clamp_v = range_min;
         end
         if (clamp_v > range_max) begin
            clamp_v = range_max;
         end
      end
   end

   assign edge_lo = (item.edge_a < item.edge_b) ? item.edge_a : item.edge_b;
   assign edge_hi = (item.edge_a < item.edge_b) ? item.edge_b : item.edge_a;

   // band write goes straight to the table; the engine then sits in done,
   // so no sample read can overlap it
   assign mem_we          = ctl.start && (item.kind == abcls_pkg::KIND_BAND) &&
                            (32'(item.slot) < BAND_SLOTS);
   assign mem_waddr       = IDX_W'(item.slot);
   assign mem_wdata.lower = edge_lo;
   assign mem_wdata.upper = edge_hi;
   assign mem_wdata.level = item.severity;

   always_comb begin
      case (state_ff)
         ST_HINT: mem_raddr = '0;
         ST_SCAN: mem_raddr = IDX_W'(32'(ptr_ff) + 32'd1);
         default: mem_raddr = hint_ff;
      endcase
   end

   assign holds    = (v_ff >= mem_rdata.lower) && (v_ff <= mem_rdata.upper);
   assign hint_hit = hint_valid_ff && (32'(hint_ff) < 32'(count)) && holds;

   assign diff0 = {1'b0, now_ff} - {1'b0, last_ff[0]};
   assign diff1 = {1'b0, now_ff} - {1'b0, last_ff[1]};

   assign changed = armed_ff &&
                    ((found_ff != rec_valid_ff) || (found_ff && (idx_ff != rec_ff)));
   assign blocked = (lvl_ff == abcls_pkg::SEV_WARN) ? (blk_ff[0] || blk_ff[1]) : blk_ff[1];

   always_comb begin
      alert_code = abcls_pkg::ALERT_NONE;
      if (changed && found_ff && (lvl_ff >= abcls_pkg::SEV_WARN) && !blocked) begin
         alert_code = (lvl_ff == abcls_pkg::SEV_CRIT) ? abcls_pkg::ALERT_CRIT
                                                      : abcls_pkg::ALERT_WARN;
      end
   end

   always_comb begin
      state_in      = state_ff;
      wr_in         = wr_ff;
      v_in          = v_ff;
      now_in        = now_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      lvl_in        = lvl_ff;
      blk_in        = blk_ff;
      hint_in       = hint_ff;
      hint_valid_in = hint_valid_ff;
      rec_in        = rec_ff;
      rec_valid_in  = rec_valid_ff;
      armed_in      = armed_ff;
      last_in       = last_ff;
      tvalid_in     = tvalid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               wr_in    = item.kind;
               v_in     = clamp_v;
               now_in   = item.time_ms;
               found_in = 1'b0;
               idx_in   = '0;
               lvl_in   = '0;
               if (item.kind == abcls_pkg::KIND_BAND) begin
                  // re-arm
                  hint_valid_in = 1'b0;
                  hint_in       = '0;
                  rec_valid_in  = 1'b0;
                  rec_in        = '0;
                  armed_in      = 1'b0;
                  tvalid_in     = 2'b00;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_HINT;
               end
            end
         end
         ST_HINT: begin
            if (hint_hit) begin
               found_in = 1'b1;
               idx_in   = hint_ff;
               lvl_in   = mem_rdata.level;
               state_in = ST_CHECK;
            end else if (count == '0) begin
               state_in = ST_CHECK;
            end else begin
               ptr_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (holds) begin
               found_in = 1'b1;
               idx_in   = ptr_ff;
               lvl_in   = mem_rdata.level;
               state_in = ST_CHECK;
            end else if ((32'(ptr_ff) + 32'd1) >= 32'(count)) begin
               state_in = ST_CHECK;
            end else begin
               ptr_in = IDX_W'(32'(ptr_ff) + 32'd1);
            end
         end
         ST_CHECK: begin
            // an earlier time than the stored one counts as inside the holdoff
            blk_in[0] = tvalid_ff[0] && (diff0[48] || (diff0[47:0] < {28'd0, holdoff_ms}));
            blk_in[1] = tvalid_ff[1] && (diff1[48] || (diff1[47:0] < {28'd0, holdoff_ms}));
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (ctl.take) begin
               state_in = ST_IDLE;
               if (!wr_ff) begin
                  if (found_ff) begin
                     hint_in       = idx_ff;
                     hint_valid_in = 1'b1;
                  end
                  if (!armed_ff || changed) begin
                     armed_in     = 1'b1;
                     rec_valid_in = found_ff;
                     rec_in       = found_ff ? idx_ff : '0;
                  end
                  if (alert_code != abcls_pkg::ALERT_NONE) begin
                     last_in[lvl_ff[0]]   = now_ff;
                     tvalid_in[lvl_ff[0]] = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hint_valid_ff <= 1'b0;
         hint_ff       <= '0;
         rec_valid_ff  <= 1'b0;
         rec_ff        <= '0;
         armed_ff      <= 1'b0;
         tvalid_ff     <= 2'b00;
         last_ff[0]    <= '0;
         last_ff[1]    <= '0;
      end else begin
         state_ff      <= state_in;
         hint_valid_ff <= hint_valid_in;
         hint_ff       <= hint_in;
         rec_valid_ff  <= rec_valid_in;
         rec_ff        <= rec_in;
         armed_ff      <= armed_in;
         tvalid_ff     <= tvalid_in;
         last_ff[0]    <= last_in[0];
         last_ff[1]    <= last_in[1];
      end
   end

   always_ff @(posedge clock) begin
      wr_ff    <= wr_in;
      v_ff     <= v_in;
      now_ff   <= now_in;
      ptr_ff   <= ptr_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      lvl_ff   <= lvl_in;
      blk_ff   <= blk_in;
   end

   assign sts.idle = (state_ff == ST_IDLE);
   assign sts.done = (state_ff == ST_DONE);

   always_comb begin
      result = '0;
      if (!wr_ff) begin
         result.in_band       = found_ff;
         result.band_index    = found_ff ? 3'(idx_ff) : 3'd0;
         result.band_changed  = changed;
         result.alert         = alert_code;
         result.value_clamped = v_ff;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/alarm_band_classifier_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_band_classifier_core
// classifies samples against a band table and raises warning/critical alerts
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: a band write (kind 1) stores a table
//   entry and re-arms, a sample (kind 0) is clamped and matched to a band.
//   rsp_* returns exactly one result per item, in order; a band write answers
//   with an all-zero result. csr_* writes range_min, range_max, band_count and
//   holdoff_ms; write it only while no item is in flight.
//   Sequence: a band write goes straight to the done state. A sample first
//   tries the previously matched band; if that band no longer holds it and
//   the table is not empty, the engine scans the entries in order, at most
//   band_count (capped at BAND_SLOTS), then checks the holdoff. The scan reads
//   one entry per cycle through the single read port of the band table memory.
//   Items are taken one at a time; the next transfer is accepted once the
//   engine has handed its result to the output register.
//   A stalled rsp_* holds its result while the next item proceeds; that item
//   then waits in the engine and req_stall stays high until the result moves.
//   Reset clears arming, holdoff history and the registers (holdoff 3000 ms);
//   the band table is not cleared and must be written before use.
// ----------------------------------------------------------------------------
`include "alarm_band_classifier_core_assert.svh"

module alarm_band_classifier_core #(
   parameter int unsigned BAND_SLOTS = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  abcls_pkg::abcls_req_type req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output abcls_pkg::abcls_rsp_type rsp_data,
   input  wire                      csr_we,
   input  wire [1:0]                csr_addr,
   input  wire [31:0]               csr_wdata
);

   localparam int unsigned IDX_W = (BAND_SLOTS > 1) ? $clog2(BAND_SLOTS) : 1;

   logic signed [31:0] range_min_ff, range_min_in;
   logic signed [31:0] range_max_ff, range_max_in;
   logic [3:0]         band_count_ff, band_count_in;
   logic [19:0]        holdoff_ff, holdoff_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   abcls_pkg::abcls_rsp_type rsp_data_ff, rsp_data_in;

   abcls_pkg::abcls_eng_ctl_type    eng_ctl;
   abcls_pkg::abcls_eng_sts_type    eng_sts;
   abcls_pkg::abcls_rsp_type        eng_result;
   logic                            mem_we;
   logic [IDX_W-1:0]                mem_waddr;
   abcls_pkg::abcls_band_entry_type mem_wdata;
   logic [IDX_W-1:0]                mem_raddr;
   abcls_pkg::abcls_band_entry_type mem_rdata;

   // configuration registers
   always_comb begin
      range_min_in  = range_min_ff;
      range_max_in  = range_max_ff;
      band_count_in = band_count_ff;
      holdoff_in    = holdoff_ff;
      if (csr_we) begin
         case (csr_addr)
            abcls_pkg::CSR_RANGE_MIN:  range_min_in  = csr_wdata;
            abcls_pkg::CSR_RANGE_MAX:  range_max_in  = csr_wdata;
            abcls_pkg::CSR_BAND_COUNT: band_count_in = csr_wdata[3:0];
            abcls_pkg::CSR_HOLDOFF_MS: holdoff_in    = csr_wdata[19:0];
            default: begin
               range_min_in = range_min_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff  <= '0;
         range_max_ff  <= '0;
         band_count_ff <= '0;
         holdoff_ff    <= abcls_pkg::HOLDOFF_RESET;
      end else begin
         range_min_ff  <= range_min_in;
         range_max_ff  <= range_max_in;
         band_count_ff <= band_count_in;
         holdoff_ff    <= holdoff_in;
      end
   end

   assign req_stall     = !eng_sts.idle;
   assign eng_ctl.start = req_valid && eng_sts.idle;
   // result moves on when the output register is empty or draining
   assign eng_ctl.take  = eng_sts.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (eng_ctl.take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   abcls_band_mem #(
      .BAND_SLOTS (BAND_SLOTS),
      .IDX_W      (IDX_W)
   ) u_band_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   abcls_engine #(
      .BAND_SLOTS (BAND_SLOTS),
      .IDX_W      (IDX_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .ctl        (eng_ctl),
      .item       (req_data),
      .range_min  (range_min_ff),
      .range_max  (range_max_ff),
      .band_count (band_count_ff),
      .holdoff_ms (holdoff_ff),
      .sts        (eng_sts),
      .result     (eng_result),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   `ABCLS_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, req_stall, "engine did not go busy after an input transfer")
   `ABCLS_ASSERT_NEXT(a_rsp_needs_done, clock, reset, !rsp_valid && !eng_sts.done, !rsp_valid, "result appeared without a finished item")
   `ABCLS_ASSERT_NEXT(a_done_holds, clock, reset, eng_sts.done && !eng_ctl.take, eng_sts.done, "finished result dropped while output was blocked")
   `ABCLS_ASSERT_NOW(a_alert_on_change, clock, reset, rsp_valid && (rsp_data.alert != abcls_pkg::ALERT_NONE), rsp_data.band_changed && rsp_data.in_band, "alert raised without a band change")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the alarm band classifier: band table loads,
// clamping, band tracking and alert holdoff are predicted per transfer and
// every result is compared field by field, under random idling on both sides
// ----------------------------------------------------------------------------
module tb_top;

   localparam int QUIET_LIMIT = 2000;
   localparam int NUM_SLOTS   = 8;

   localparam logic [1:0] SEV_QUIET = 2'd0;
   localparam logic [1:0] SEV_NOTE  = 2'd1;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   abcls_pkg::abcls_req_type req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   abcls_pkg::abcls_rsp_type rsp_data;
   logic                     csr_we    = 1'b0;
   logic [1:0]               csr_addr  = abcls_pkg::CSR_RANGE_MIN;
   logic [31:0]              csr_wdata = '0;

   // predicted register and block state
   logic signed [31:0] cfg_min     = '0;
   logic signed [31:0] cfg_max     = '0;
   logic [3:0]         cfg_count   = '0;
   logic [19:0]        cfg_holdoff = abcls_pkg::HOLDOFF_RESET;
   logic signed [31:0] band_lo  [NUM_SLOTS] = '{default: '0};
   logic signed [31:0] band_hi  [NUM_SLOTS] = '{default: '0};
   logic [1:0]         band_lvl [NUM_SLOTS] = '{default: '0};
   logic [2:0]         hint_slot = '0;
   bit                 hint_ok   = 1'b0;
   logic [2:0]         rec_slot  = '0;
   bit                 rec_ok    = 1'b0;
   bit                 armed     = 1'b0;
   logic [47:0]        fired_at [2] = '{default: '0};
   bit                 fired    [2] = '{default: 1'b0};

   abcls_pkg::abcls_rsp_type band_verdicts[$];
   logic [47:0]   now_ms = '0;
   bit            req_burst = 1'b0;
   bit            rsp_burst = 1'b0;
   int            items_sent = 0;
   int            band_writes = 0;
   int            verdicts_checked = 0;
   int            alerts_seen = 0;
   int            mismatches = 0;
   int            phases_run = 0;

   alarm_band_classifier_core #(.BAND_SLOTS(NUM_SLOTS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // works out the result of one item and advances the predicted state
   function automatic abcls_pkg::abcls_rsp_type judge_item(input abcls_pkg::abcls_req_type r);
      abcls_pkg::abcls_rsp_type res;
      logic signed [31:0]       ea, eb, v;
      int                       n, i, idx, s, k;
      bit                       hit, moved, blocked;
      logic [1:0]               lvl;
      res = '0;
      if (r.kind == abcls_pkg::KIND_BAND) begin
         ea = r.edge_a;
         eb = r.edge_b;
         band_lo[r.slot]  = (ea < eb) ? ea : eb;
         band_hi[r.slot]  = (ea < eb) ? eb : ea;
         band_lvl[r.slot] = r.severity;
         hint_ok  = 1'b0;
         rec_ok   = 1'b0;
         rec_slot = '0;
         armed    = 1'b0;
         fired[0] = 1'b0;
         fired[1] = 1'b0;
         return res;
      end
      v = r.sample_value;
      if (cfg_max > cfg_min) begin
         if (v < cfg_min) v = cfg_min;
         if (v > cfg_max) v = cfg_max;
      end
      n = (cfg_count > NUM_SLOTS) ? NUM_SLOTS : cfg_count;
      hit = 1'b0;
      idx = 0;
      if (hint_ok && hint_slot < n && v >= band_lo[hint_slot] && v <= band_hi[hint_slot]) begin
         hit = 1'b1;
         idx = hint_slot;
      end
      for (i = 0; i < n && !hit; i++) begin
         if (v >= band_lo[i] && v <= band_hi[i]) begin
            hit = 1'b1;
            idx = i;
         end
      end
      if (hit) begin
         hint_slot = 3'(idx);
         hint_ok   = 1'b1;
      end
      moved = 1'b0;
      if (!armed) begin
         armed    = 1'b1;
         rec_ok   = hit;
         rec_slot = hit ? 3'(idx) : 3'd0;
      end else begin
         moved = (hit != rec_ok) || (hit && 3'(idx) != rec_slot);
         if (moved) begin
            rec_ok   = hit;
            rec_slot = hit ? 3'(idx) : 3'd0;
            if (hit && band_lvl[idx] >= abcls_pkg::SEV_WARN) begin
               lvl = band_lvl[idx];
               blocked = 1'b0;
               // any alert of this level or higher still inside the holdoff blocks it
               for (s = lvl; s <= abcls_pkg::SEV_CRIT; s++) begin
                  k = s - int'(abcls_pkg::SEV_WARN);
                  if (fired[k] && (r.time_ms < fired_at[k] ||
                      r.time_ms - fired_at[k] < cfg_holdoff))
                     blocked = 1'b1;
               end
               if (!blocked) begin
                  k = int'(lvl) - int'(abcls_pkg::SEV_WARN);
                  fired_at[k] = r.time_ms;
                  fired[k]    = 1'b1;
                  res.alert = (lvl == abcls_pkg::SEV_CRIT) ? abcls_pkg::ALERT_CRIT
                                                           : abcls_pkg::ALERT_WARN;
               end
            end
         end
      end
      res.in_band       = hit;
      res.band_index    = hit ? 3'(idx) : 3'd0;
      res.band_changed  = moved;
      res.value_clamped = v;
      return res;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // result side: each transfer is checked against the oldest prediction
   always @(posedge clock) begin
      abcls_pkg::abcls_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (band_verdicts.size() == 0) begin
            $display("%0t: result with nothing outstanding, expected none, actual %p",
                     $time, rsp_data);
            mismatches++;
         end else begin
            want = band_verdicts.pop_front();
            compare_field("in_band", want.in_band, rsp_data.in_band);
            compare_field("band_index", want.band_index, rsp_data.band_index);
            compare_field("band_changed", want.band_changed, rsp_data.band_changed);
            compare_field("alert", want.alert, rsp_data.alert);
            compare_field("value_clamped", want.value_clamped, rsp_data.value_clamped);
            verdicts_checked++;
         end
         if (rsp_data.alert != abcls_pkg::ALERT_NONE) alerts_seen++;
      end
   end

   initial begin : result_stalls
      int n;
      wait (!reset);
      @(posedge clock);
      forever begin
         n = rsp_burst ? 0 : $urandom_range(0, 12);
         repeat (n) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
   end

   task automatic send_item(input abcls_pkg::abcls_req_type item);
      int                       gap;
      abcls_pkg::abcls_rsp_type verdict;
      gap = req_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      verdict = judge_item(item);
      band_verdicts.insert(band_verdicts.size(), verdict);
      items_sent++;
   endtask

   function automatic abcls_pkg::abcls_req_type make_item(input logic kind);
      abcls_pkg::abcls_req_type it;
      it.kind         = kind;
      it.slot         = 3'($urandom_range(0, 7));
      it.edge_a       = $urandom;
      it.edge_b       = $urandom;
      it.severity     = 2'($urandom_range(0, 3));
      it.sample_value = $urandom;
      it.time_ms      = {16'($urandom), $urandom};
      return it;
   endfunction

   task automatic send_band(input logic [2:0] slot, input logic signed [31:0] a,
                            input logic signed [31:0] b, input logic [1:0] sev);
      abcls_pkg::abcls_req_type it;
      it = make_item(abcls_pkg::KIND_BAND);
      it.slot     = slot;
      it.edge_a   = a;
      it.edge_b   = b;
      it.severity = sev;
      send_item(it);
      band_writes++;
   endtask

   task automatic send_sample(input logic signed [31:0] v, input logic [47:0] t);
      abcls_pkg::abcls_req_type it;
      it = make_item(abcls_pkg::KIND_SAMPLE);
      it.sample_value = v;
      it.time_ms      = t;
      send_item(it);
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         abcls_pkg::CSR_RANGE_MIN:  cfg_min = data;
         abcls_pkg::CSR_RANGE_MAX:  cfg_max = data;
         abcls_pkg::CSR_BAND_COUNT: cfg_count = data[3:0];
         abcls_pkg::CSR_HOLDOFF_MS: cfg_holdoff = data[19:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // registers may only change once the block has gone quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (band_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [47:0] next_time();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: now_ms = now_ms + $urandom_range(0, 40);
         6, 7:             now_ms = now_ms + cfg_holdoff + $urandom_range(0, 4) - 2;
         8:                now_ms = now_ms + $urandom_range(0, 2000000);
         default:          now_ms = now_ms - $urandom_range(0, 100);
      endcase
      return now_ms;
   endfunction

   // empty table and default registers: nothing matches, nothing is clamped
   task automatic test_after_reset();
      send_sample(32'sh7FFF_FFFF, 48'd0);
      send_sample(32'sh8000_0000, 48'hFFFF_FFFF_FFFF);
      send_sample(32'sd0, 48'd5);
   endtask

   // every slot gets written before any count above zero is set
   task automatic test_band_load();
      send_band(3'd0, 32'sd100, -32'sd100, SEV_QUIET);
      send_band(3'd1, 32'sd200, 32'sd400, abcls_pkg::SEV_WARN);
      send_band(3'd2, 32'sd500, 32'sd450, abcls_pkg::SEV_CRIT);
      send_band(3'd3, 32'sd300, 32'sd350, SEV_NOTE);
      send_band(3'd4, 32'sh7FFF_FFFF, 32'sd1000, abcls_pkg::SEV_CRIT);
      send_band(3'd5, 32'sh8000_0000, -32'sd5000, abcls_pkg::SEV_WARN);
      send_band(3'd6, -32'sd2000, -32'sd3000, abcls_pkg::SEV_WARN);
      send_band(3'd7, -32'sd7, -32'sd7, SEV_NOTE);
      wait_idle();
      set_reg(abcls_pkg::CSR_BAND_COUNT, 32'd8);
      set_reg(abcls_pkg::CSR_HOLDOFF_MS, 32'd100);
   endtask

   task automatic test_alert_path();
      send_sample(32'sd0, 48'd1000);
      send_sample(32'sd300, 48'd1010);
      send_sample(32'sd320, 48'd1020);
      send_sample(32'sd475, 48'd1030);
      send_sample(32'sd250, 48'd1040);
      send_sample(32'sd900, 48'd1050);
      send_sample(32'sd480, 48'd1000);
      send_sample(32'sd900, 48'd1290);
      send_sample(32'sd480, 48'd1300);
   endtask

   // a remembered band past the count is skipped, a count past the table is capped
   task automatic test_hint_and_count();
      send_sample(-32'sd2500, 48'd1400);
      wait_idle();
      set_reg(abcls_pkg::CSR_BAND_COUNT, 32'd3);
      send_sample(-32'sd2500, 48'd1410);
      wait_idle();
      set_reg(abcls_pkg::CSR_BAND_COUNT, 32'd15);
      send_sample(-32'sd2500, 48'd1420);
   endtask

   task automatic test_clamping();
      wait_idle();
      set_reg(abcls_pkg::CSR_RANGE_MIN, -32'sd100);
      set_reg(abcls_pkg::CSR_RANGE_MAX, 32'sd100);
      send_sample(32'sh7FFF_FFFF, 48'd1500);
      send_sample(32'sh8000_0000, 48'd1510);
      wait_idle();
      set_reg(abcls_pkg::CSR_RANGE_MAX, -32'sd100);
      send_sample(32'sh7FFF_FFFF, 48'd1520);
   endtask

   task automatic test_random_traffic(input int target);
      int                 n, k, s;
      logic signed [31:0] lo, hi, v;
      while (items_sent < target) begin
         wait_idle();
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         if (phases_run == 0) begin
            set_reg(abcls_pkg::CSR_RANGE_MIN, 32'h8000_0000);
            set_reg(abcls_pkg::CSR_RANGE_MAX, 32'h7FFF_FFFF);
            set_reg(abcls_pkg::CSR_BAND_COUNT, 32'd8);
            set_reg(abcls_pkg::CSR_HOLDOFF_MS, 32'd1048575);
         end else if (phases_run == 1) begin
            set_reg(abcls_pkg::CSR_RANGE_MIN, 32'd0);
            set_reg(abcls_pkg::CSR_RANGE_MAX, 32'd0);
            set_reg(abcls_pkg::CSR_BAND_COUNT, 32'd0);
            set_reg(abcls_pkg::CSR_HOLDOFF_MS, 32'd0);
         end else begin
            lo = -int'($urandom_range(0, 600));
            hi = int'($urandom_range(0, 600));
            case ($urandom_range(0, 3))
               0: begin
                  set_reg(abcls_pkg::CSR_RANGE_MIN, 32'd0);
                  set_reg(abcls_pkg::CSR_RANGE_MAX, 32'd0);
               end
               1: begin
                  set_reg(abcls_pkg::CSR_RANGE_MIN, lo);
                  set_reg(abcls_pkg::CSR_RANGE_MAX, hi);
               end
               2: begin
                  // inverted range leaves values unclamped
                  set_reg(abcls_pkg::CSR_RANGE_MIN, hi);
                  set_reg(abcls_pkg::CSR_RANGE_MAX, lo);
               end
               default: begin
                  set_reg(abcls_pkg::CSR_RANGE_MIN, $urandom);
                  set_reg(abcls_pkg::CSR_RANGE_MAX, $urandom);
               end
            endcase
            set_reg(abcls_pkg::CSR_BAND_COUNT,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 8);
            case ($urandom_range(0, 4))
               0:       set_reg(abcls_pkg::CSR_HOLDOFF_MS, 32'd0);
               1:       set_reg(abcls_pkg::CSR_HOLDOFF_MS, 32'(abcls_pkg::HOLDOFF_RESET));
               2:       set_reg(abcls_pkg::CSR_HOLDOFF_MS, $urandom_range(0, 200));
               3:       set_reg(abcls_pkg::CSR_HOLDOFF_MS, $urandom_range(0, 1048575));
               default: set_reg(abcls_pkg::CSR_HOLDOFF_MS, 32'd20);
            endcase
         end
         if ($urandom_range(0, 4) == 0) now_ms = {16'($urandom), $urandom};
         // most phases load fresh bands, which also re-arms
         if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 19) == 0) begin
                  send_band(3'($urandom_range(0, 7)), $urandom, $urandom,
                            2'($urandom_range(0, 3)));
               end else begin
                  lo = int'($urandom_range(0, 1000)) - 500;
                  hi = lo + int'($urandom_range(0, 300));
                  if ($urandom_range(0, 1))
                     send_band(3'($urandom_range(0, 7)), lo, hi, 2'($urandom_range(0, 3)));
                  else
                     send_band(3'($urandom_range(0, 7)), hi, lo, 2'($urandom_range(0, 3)));
               end
            end
         end
         n = $urandom_range(20, 60);
         repeat (n) begin
            k = $urandom_range(0, 99);
            if (k < 3) begin
               send_band(3'($urandom_range(0, 7)), $urandom, $urandom,
                         2'($urandom_range(0, 3)));
            end else begin
               if (k < 70) begin
                  s = $urandom_range(0, 7);
                  v = ($urandom_range(0, 1) ? band_lo[s] : band_hi[s]) +
                      int'($urandom_range(0, 6)) - 3;
               end else if (k < 90) begin
                  v = int'($urandom_range(0, 1600)) - 800;
               end else begin
                  v = $urandom;
               end
               send_sample(v, next_time());
            end
         end
         phases_run++;
      end
      wait_idle();
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_after_reset();
      test_band_load();
      test_alert_path();
      test_hint_and_count();
      test_clamping();
      test_random_traffic(1550);
      repeat (20) @(posedge clock);
      $display("covered %0d items (%0d band writes) over %0d random phases",
               items_sent, band_writes, phases_run);
      $display("checked %0d results, %0d of them raised alerts", verdicts_checked, alerts_seen);
      if (mismatches == 0 && band_verdicts.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/abcls_pkg.sv
hw/rtl/abcls_band_mem.sv
hw/rtl/abcls_engine.sv
hw/rtl/alarm_band_classifier_core.sv
tb/tb_top.sv
